### src/sha1_pkg.sv
// Package for the SHA-1 digest block: payload types, constants and round helpers.
// Used by every module in src; depends on nothing else.
package sha1_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_item;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } sha1_out_t;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       start;
        logic       step;
        logic [6:0] round;
        logic       finish;
    } sha1_core_ctl_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    // Round constant for a given round number.
    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = 32'h5a827999;
        else if (r < 7'd40) k = 32'h6ed9eba1;
        else if (r < 7'd60) k = 32'h8f1bbcdc;
        else                k = 32'hca62c1d6;
        return k;
    endfunction

    // Round function for a given round number.
    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)      f = (b & c) | (~b & d);
        else if (r < 7'd40) f = b ^ c ^ d;
        else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

endpackage

### src/sha1_core.sv
// SHA-1 compression unit, one round per cycle while ctl.step is high, with a 16-word rolling schedule.
// Depends on sha1_pkg. The block words are loaded in parallel at start.
module sha1_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha1_pkg::sha1_core_ctl_t ctl,
    input  logic [511:0]            block,
    output logic [159:0]            chain
);
    import sha1_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h_reg [5];
    logic [31:0] w_new, t_next;

    // Next schedule word and round sum from the current window.
    assign w_new  = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                  | (w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]) >> 31;
    assign t_next = {a_reg[26:0], a_reg[31:27]} + round_f(ctl.round, b_reg, c_reg, d_reg)
                  + e_reg + w_reg[0] + round_k(ctl.round);

    // Working registers and schedule window.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32*i -: 32];
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (ctl.step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining words: updated after round 79, back to the initial vector after output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
            h_reg[3] <= IV3; h_reg[4] <= IV4;
        end
        else if (ctl.finish)
        begin
            h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
            h_reg[3] <= IV3; h_reg[4] <= IV4;
        end
        else if (ctl.step && ctl.round == LAST_ROUND)
        begin
            h_reg[0] <= h_reg[0] + t_next;
            h_reg[1] <= h_reg[1] + a_reg;
            h_reg[2] <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
            h_reg[3] <= h_reg[3] + c_reg;
            h_reg[4] <= h_reg[4] + d_reg;
        end
    end

    assign chain = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

endmodule

### src/sha1_message_digest.sv
// SHA-1 digest block. An accepted word is unpacked one byte per cycle, except while
// a full block is compressed, into the 16-word block store; the input stays busy
// until all its valid bytes (at most four) are stored. Each time the 64th byte lands,
// the block is loaded into the round unit and compressed (a load state, then 80
// rounds through a single shared round adder), and no new word is taken meanwhile.
// A last item then pads at one byte per cycle up to the end of the
// block, runs one or two such compressions (a second one when the 0x80 marker lands
// at byte 56 or later), and delivers the digest as five output transfers, word 0
// first; the receiver may stall each of them. No input is taken until the fifth
// digest word has been transferred.
module sha1_message_digest (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sha1_pkg::sha1_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sha1_pkg::sha1_out_t  out_data
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PACK = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;

    logic [2:0]   state_reg;
    logic [15:0][3:0][7:0] blk_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  len_reg;
    logic [31:0]  word_reg;
    logic [2:0]   left_reg;
    logic         last_reg;
    logic         padded_reg;
    logic         final_reg;
    logic [6:0]   round_reg;
    logic [2:0]   oidx_reg;
    logic [511:0] block;
    logic [159:0] chain;
    logic [2:0]   cnt;
    logic [7:0]   pbyte;
    logic [63:0]  bit_len;
    logic [7:0]   len_byte;
    logic         wr_en;
    logic [7:0]   wr_byte;
    sha1_core_ctl_t ctl;

    assign cnt = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;

    // Big-endian bit length; byte 56 of the final block carries its top byte.
    assign bit_len  = {len_reg, 3'b000};
    assign len_byte = 8'(bit_len >> {~fill_reg[2:0], 3'b000});

    // Byte to place in the padding phase.
    always_comb
    begin
        if (!padded_reg)
            pbyte = 8'h80;
        else if (final_reg && fill_reg >= 6'd56)
            pbyte = len_byte;
        else
            pbyte = 8'h00;
    end

    // Byte written into the block store this cycle.
    assign wr_en   = (state_reg == S_PACK && left_reg != 3'd0) || state_reg == S_PAD;
    assign wr_byte = (state_reg == S_PAD) ? pbyte : word_reg[31:24];

    // Block store: byte 0 of the block sits in the top byte of word 0.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            blk_reg[~fill_reg[5:2]][~fill_reg[1:0]] <= wr_byte;
    end

    assign block = blk_reg;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_data.digest_word = chain[159 - 32*oidx_reg -: 32];
    assign out_data.word_index  = oidx_reg;
    assign out_data.digest_done = (oidx_reg == 3'd4);

    assign ctl.start  = (state_reg == S_LOAD);
    assign ctl.step   = (state_reg == S_RUN);
    assign ctl.round  = round_reg;
    assign ctl.finish = out_valid && out_ready && oidx_reg == 3'd4;

    // Sequencer: pack bytes one per cycle between compressions, pad, run rounds, deliver digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            word_reg   <= '0;
            left_reg   <= '0;
            last_reg   <= 1'b0;
            round_reg  <= '0;
            oidx_reg   <= '0;
            padded_reg <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        word_reg  <= in_data.data_word;
                        left_reg  <= cnt;
                        last_reg  <= in_data.last_item;
                        len_reg   <= len_reg + 61'(cnt);
                        state_reg <= S_PACK;
                    end
                end
                S_PACK:
                begin
                    if (left_reg == 3'd0)
                    begin
                        padded_reg <= 1'b0;
                        state_reg  <= last_reg ? S_PAD : S_IDLE;
                    end
                    else
                    begin
                        word_reg <= {word_reg[23:0], 8'h00};
                        left_reg <= left_reg - 3'd1;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                            state_reg <= S_LOAD;
                    end
                end
                S_PAD:
                begin
                    // The length fits in this block only if the marker lands before byte 56.
                    if (!padded_reg)
                        final_reg <= (fill_reg < 6'd56);
                    padded_reg <= 1'b1;
                    fill_reg   <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    round_reg <= '0;
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == LAST_ROUND)
                    begin
                        if (!padded_reg)
                            state_reg <= S_PACK;
                        else if (final_reg)
                            state_reg <= S_OUT;
                        else
                        begin
                            final_reg <= 1'b1;
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (oidx_reg == 3'd4)
                        begin
                            oidx_reg   <= '0;
                            fill_reg   <= '0;
                            len_reg    <= '0;
                            final_reg  <= 1'b0;
                            padded_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                        else
                            oidx_reg <= oidx_reg + 3'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .block (block),
        .chain (chain)
    );

    // Digest words leave in order; no input during digest or rounds; rounds stop after 79.
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && oidx_reg != 3'd4 |=> oidx_reg == $past(oidx_reg) + 3'd1)
        else $error("digest index skipped");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid && !ctl.step)
        else $error("input taken while busy");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && round_reg == LAST_ROUND |=> state_reg != S_RUN)
        else $error("round count overran");

endmodule
